/* sv/barometric_sensor_compensation_unit_assert.svh */
// Assertion macros shared by the block's modules.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_UNIT_ASSERT_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_UNIT_ASSERT_SVH

// Property that must hold at every edge once out of reset.
`define BSC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define BSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/bsc_pkg.sv */
package bsc_pkg;

	localparam int unsigned DataW   = 32;
	localparam int unsigned RawW    = 19;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] REG_TEMP_CAL  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_PRESS_A   = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_PRESS_B   = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_OSS       = 2'd3;

	localparam logic OP_TEMP  = 1'b0;
	localparam logic OP_PRESS = 1'b1;

	// ALU operations of the datapath
	localparam int unsigned AluOpW = 5;
	typedef logic [AluOpW-1:0] alu_op_t;

	localparam alu_op_t A_T_X1      = 5'd0;  // x1 = asr((ut-ac6)*ac5,15)
	localparam alu_op_t A_T_DEN     = 5'd1;  // den = x1+md ; num = mc<<11
	localparam alu_op_t A_T_B5      = 5'd2;  // b5 = x1+q
	localparam alu_op_t A_P_B6      = 5'd3;  // b6 = b5-4000
	localparam alu_op_t A_P_SQ      = 5'd4;  // sq = asr(b6*b6,12)
	localparam alu_op_t A_P_X1A     = 5'd5;  // ta = asr(b2*sq,11)
	localparam alu_op_t A_P_X2A     = 5'd6;  // tb = asr(ac2*b6,11)
	localparam alu_op_t A_P_B3      = 5'd7;  // b3
	localparam alu_op_t A_P_X1B     = 5'd8;  // ta = asr(ac3*b6,13)
	localparam alu_op_t A_P_X2B     = 5'd9;  // tb = asr(b1*sq,16)
	localparam alu_op_t A_P_X3      = 5'd10; // ta = asr(ta+tb+2,2)
	localparam alu_op_t A_P_B4      = 5'd11; // b4
	localparam alu_op_t A_P_B7      = 5'd12; // b7
	localparam alu_op_t A_P_DIVSET  = 5'd13; // load divider operands
	localparam alu_op_t A_P_PFIX    = 5'd14; // p from quotient
	localparam alu_op_t A_P_PS      = 5'd15; // ta = asr(p,8)^2
	localparam alu_op_t A_P_X1C     = 5'd16; // ta = asr(ta*3038,16)
	localparam alu_op_t A_P_X2C     = 5'd17; // tb = asr(-7357*p,16)
	localparam alu_op_t A_P_FIN     = 5'd18; // value
	localparam alu_op_t A_T_FIN     = 5'd19; // temperature value
	localparam alu_op_t A_NONE      = 5'd20;

	typedef struct packed {
		logic    op_en;
		alu_op_t op;
		logic    div_start;
		logic    err_set;
		logic    clear;
	} bsc_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_zero;
	} bsc_stat_t;

endpackage

/* sv/bsc_div.sv */
// Restoring unsigned divider, one quotient bit a cycle.
`include "barometric_sensor_compensation_unit_assert.svh"
module bsc_div #(
	parameter int unsigned W = bsc_pkg::DataW
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic [W-1:0] quotient
);
	localparam int unsigned CntW = $clog2(W + 1);

	logic [W-1:0]    quo_q;
	logic [W-1:0]    rem_q;
	logic [W-1:0]    dsr_q;
	logic [CntW-1:0] cnt_q;
	logic [W:0]      trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CntW'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

	`BSC_ASSERT_NEXT(a_div_start, clk, arst_n, start, busy, "divider did not start")
	`BSC_ASSERT(a_div_cnt, clk, arst_n, cnt_q <= CntW'(W), "divider count out of range")
	`BSC_ASSERT_NEXT(a_div_dec, clk, arst_n, busy && !start, cnt_q == $past(cnt_q) - 1'b1,
		"divider count did not advance")
endmodule

/* sv/bsc_datapath.sv */
// Shared multiplier datapath with scratch registers and the divider.
module bsc_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bsc_pkg::bsc_cmd_t          cmd,
	output bsc_pkg::bsc_stat_t         stat,
	input  logic [18:0]                raw,
	input  logic [63:0]                tcal,
	input  logic [63:0]                pcal_a,
	input  logic [31:0]                pcal_b,
	input  logic [1:0]                 oss,
	output logic [bsc_pkg::DataW-1:0]  result,
	output logic                       err
);
	logic [31:0] b5_q, x1_q, ta_q, tb_q, b6_q, sq_q, b3_q, b4_q, b7_q, p_q, val_q;
	logic        neg_q, big_q, err_q;
	logic [31:0] mul_a, mul_b, prod, sum;
	logic [31:0] dvd, dvs, quo;
	logic        dbusy;
	logic [31:0] ac5, ac6, mc, md, ac1, ac2, ac3, ac4, b1, b2, nd, nn;

	function automatic logic [31:0] sx(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	assign ac5 = {16'd0, tcal[63:48]};
	assign ac6 = {16'd0, tcal[47:32]};
	assign mc  = sx(tcal[31:16]);
	assign md  = sx(tcal[15:0]);
	assign ac1 = sx(pcal_a[63:48]);
	assign ac2 = sx(pcal_a[47:32]);
	assign ac3 = sx(pcal_a[31:16]);
	assign ac4 = {16'd0, pcal_a[15:0]};
	assign b1  = sx(pcal_b[31:16]);
	assign b2  = sx(pcal_b[15:0]);

	// one 32x32 multiplier; low 32 bits only
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			bsc_pkg::A_T_X1:  begin mul_a = {13'd0, raw} & 32'h0000_FFFF; mul_a = mul_a - ac6;
				mul_b = ac5; end
			bsc_pkg::A_P_SQ:  begin mul_a = b6_q; mul_b = b6_q; end
			bsc_pkg::A_P_X1A: begin mul_a = b2; mul_b = sq_q; end
			bsc_pkg::A_P_X2A: begin mul_a = ac2; mul_b = b6_q; end
			bsc_pkg::A_P_X1B: begin mul_a = ac3; mul_b = b6_q; end
			bsc_pkg::A_P_X2B: begin mul_a = b1; mul_b = sq_q; end
			bsc_pkg::A_P_B4:  begin mul_a = ac4; mul_b = ta_q + 32'd32768; end
			bsc_pkg::A_P_B7:  begin mul_a = {13'd0, raw} - b3_q;
				mul_b = 32'd50000 >> oss; end
			bsc_pkg::A_P_PS:  begin mul_a = $signed(p_q) >>> 8; mul_b = $signed(p_q) >>> 8; end
			bsc_pkg::A_P_X1C: begin mul_a = ta_q; mul_b = 32'd3038; end
			bsc_pkg::A_P_X2C: begin mul_a = 32'hFFFF_E343; mul_b = p_q; end
			default: ;
		endcase
	end
	assign prod = mul_a * mul_b;
	assign sum  = x1_q + md;
	assign nd   = sum[31] ? 32'd0 - sum : sum;
	assign nn   = mc[20] ? 32'd0 - (mc << 11) : (mc << 11);

	always_comb begin
		dvd = nn;
		dvs = nd;
		if (cmd.op == bsc_pkg::A_P_DIVSET) begin
			dvd = big_q ? b7_q : (b7_q << 1);
			dvs = b4_q;
		end
	end

	bsc_div #(.W(bsc_pkg::DataW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(dvd), .divisor(dvs), .busy(dbusy), .quotient(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b5_q  <= '0;
			err_q <= 1'b0;
		end else begin
			if (cmd.clear) err_q <= 1'b0;
			if (cmd.err_set) err_q <= 1'b1;
			if (cmd.op_en && cmd.op == bsc_pkg::A_T_B5)
				b5_q <= x1_q + (neg_q ? 32'd0 - quo : quo);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) val_q <= '0;
		if (cmd.op_en) begin
			case (cmd.op)
				bsc_pkg::A_T_X1:  x1_q <= $signed(prod) >>> 15;
				bsc_pkg::A_T_DEN: begin x1_q <= x1_q; neg_q <= mc[20] ^ sum[31]; end
				bsc_pkg::A_T_FIN: val_q <= $signed(b5_q + 32'd8) >>> 4;
				bsc_pkg::A_P_B6:  b6_q <= b5_q - 32'd4000;
				bsc_pkg::A_P_SQ:  sq_q <= $signed(prod) >>> 12;
				bsc_pkg::A_P_X1A: ta_q <= $signed(prod) >>> 11;
				bsc_pkg::A_P_X2A: tb_q <= $signed(prod) >>> 11;
				bsc_pkg::A_P_B3:  b3_q <= $signed(((ac1 << 2) + ta_q + tb_q) << oss) + 32'sd2
					>>> 2;
				bsc_pkg::A_P_X1B: ta_q <= $signed(prod) >>> 13;
				bsc_pkg::A_P_X2B: tb_q <= $signed(prod) >>> 16;
				bsc_pkg::A_P_X3:  ta_q <= $signed(ta_q + tb_q + 32'd2) >>> 2;
				bsc_pkg::A_P_B4:  b4_q <= prod >> 15;
				bsc_pkg::A_P_B7:  begin b7_q <= prod; big_q <= prod[31]; end
				bsc_pkg::A_P_PFIX: p_q <= big_q ? (quo << 1) : quo;
				bsc_pkg::A_P_PS:  ta_q <= prod;
				bsc_pkg::A_P_X1C: ta_q <= $signed(prod) >>> 16;
				bsc_pkg::A_P_X2C: tb_q <= $signed(prod) >>> 16;
				bsc_pkg::A_P_FIN: val_q <= p_q + $unsigned($signed(ta_q + tb_q + 32'd3791) >>> 4);
				default: ;
			endcase
		end
	end

	assign stat.div_busy = dbusy;
	assign stat.div_zero = (cmd.op == bsc_pkg::A_P_DIVSET) ? (b4_q == '0) : (sum == '0);
	assign result = val_q;
	assign err    = err_q;
endmodule

/* sv/bsc_ctrl.sv */
// Sequencer: steps the datapath through the temperature or pressure recipe.
`include "barometric_sensor_compensation_unit_assert.svh"
module bsc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                opcode,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                kind,
	output bsc_pkg::bsc_cmd_t   cmd,
	input  bsc_pkg::bsc_stat_t  stat
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_STEP = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_DONE = 3'd3;

	logic [2:0]           state_q;
	bsc_pkg::alu_op_t     op_q;
	logic                 kind_q;
	logic                 ovalid_q;

	assign in_ready  = (state_q == S_IDLE) && !ovalid_q;
	assign out_valid = ovalid_q;
	assign kind      = kind_q;

	always_comb begin
		cmd = '{op_en: 1'b0, op: op_q, div_start: 1'b0, err_set: 1'b0, clear: 1'b0};
		if (state_q == S_IDLE && in_valid && in_ready) cmd.clear = 1'b1;
		if (state_q == S_STEP) begin
			if (op_q == bsc_pkg::A_T_DEN || op_q == bsc_pkg::A_P_DIVSET) begin
				if (stat.div_zero) cmd.err_set = 1'b1;
				else cmd.div_start = 1'b1;
				cmd.op_en = 1'b1;
			end else begin
				cmd.op_en = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= bsc_pkg::A_NONE;
			kind_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						kind_q  <= opcode;
						op_q    <= (opcode == bsc_pkg::OP_TEMP) ? bsc_pkg::A_T_X1 : bsc_pkg::A_P_B6;
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					case (op_q)
						bsc_pkg::A_T_DEN, bsc_pkg::A_P_DIVSET: begin
							state_q <= stat.div_zero ? S_DONE : S_DIV;
						end
						bsc_pkg::A_T_B5:  op_q <= bsc_pkg::A_T_FIN;
						bsc_pkg::A_T_FIN, bsc_pkg::A_P_FIN: state_q <= S_DONE;
						default: op_q <= op_q + 1'b1;
					endcase
				end
				S_DIV: begin
					if (!stat.div_busy) begin
						op_q    <= (op_q == bsc_pkg::A_T_DEN) ? bsc_pkg::A_T_B5 : bsc_pkg::A_P_PFIX;
						state_q <= S_STEP;
					end
				end
				S_DONE: begin
					ovalid_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BSC_ASSERT(a_busy_no_out, clk, arst_n, !(ovalid_q && state_q != S_IDLE),
		"result shown while busy")
	`BSC_ASSERT_NEXT(a_done_out, clk, arst_n, state_q == S_DONE, ovalid_q,
		"finished item gave no result")
	`BSC_ASSERT(a_one_start, clk, arst_n, !(cmd.div_start && cmd.err_set),
		"divider started on zero divisor")
endmodule

/* sv/barometric_sensor_compensation_unit.sv */
// Barometric compensation: send a raw temperature word (opcode 0) before pressure words
// (opcode 1); each word returns one result word. The sequencer walks the single shared
// multiplier through each step of the recipe and runs the restoring divider once; a zero
// divisor skips the division and ends the item. One word is in flight at a time; the next
// word is taken from the cycle after the result is taken. Write configuration only while
// idle. Divide by zero returns 0 with divide_error set.
`include "barometric_sensor_compensation_unit_assert.svh"
module barometric_sensor_compensation_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              opcode,
	input  logic [18:0]                       raw_sample,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              kind,
	output logic signed [bsc_pkg::DataW-1:0]  value,
	output logic                              divide_error,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [63:0]                       cfg_data
);
	logic [63:0]               tcal_q, pa_q;
	logic [31:0]               pb_q;
	logic [1:0]                oss_q;
	logic [18:0]               raw_q;
	bsc_pkg::bsc_cmd_t         cmd;
	bsc_pkg::bsc_stat_t        stat;
	logic [bsc_pkg::DataW-1:0] res;

	// config is always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcal_q <= '0;
			pa_q   <= '0;
			pb_q   <= '0;
			oss_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				bsc_pkg::REG_TEMP_CAL: tcal_q <= cfg_data;
				bsc_pkg::REG_PRESS_A:  pa_q   <= cfg_data;
				bsc_pkg::REG_PRESS_B:  pb_q   <= cfg_data[31:0];
				bsc_pkg::REG_OSS:      oss_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// hold the raw word for the whole item
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) raw_q <= raw_sample;
	end

	bsc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
		.cmd(cmd), .stat(stat)
	);

	bsc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .raw(raw_q),
		.tcal(tcal_q), .pcal_a(pa_q), .pcal_b(pb_q), .oss(oss_q),
		.result(res), .err(divide_error)
	);

	assign value = $signed(res);

	`BSC_ASSERT_NEXT(a_hold_out, clk, arst_n, out_valid && !out_ready, out_valid && $stable(value),
		"result changed while stalled")
	`BSC_ASSERT(a_err_zero, clk, arst_n, !(out_valid && divide_error) || value == '0,
		"error result not zero")
	`BSC_ASSERT(a_no_both, clk, arst_n, !(in_ready && out_valid), "accepted while result waits")
endmodule

/* test/tb.sv */
module tb;

	// Packed result word as the block returns it
	typedef struct packed {
		logic               kind;
		logic signed [31:0] value;
		logic               divide_error;
	} press_result_t;

	// Tracks calibration and the stored temperature factor, and holds the
	// results still owed by the block in arrival order.
	class compensation_scoreboard;
		logic [63:0] temp_cal;
		logic [63:0] press_cal_a;
		logic [31:0] press_cal_b;
		logic [1:0]  oss;
		logic [31:0] b5;
		press_result_t pending[$];
		int errors;
		int reported;

		function void clear_state();
			temp_cal = '0;
			press_cal_a = '0;
			press_cal_b = '0;
			oss = '0;
			b5 = '0;
			pending.delete();
			errors = 0;
			reported = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [63:0] data);
			case (idx)
				bsc_pkg::REG_TEMP_CAL: temp_cal = data;
				bsc_pkg::REG_PRESS_A: press_cal_a = data;
				bsc_pkg::REG_PRESS_B: press_cal_b = data[31:0];
				default: oss = data[1:0];
			endcase
		endfunction

		static function logic [31:0] sext(logic [15:0] v);
			return {{16{v[15]}}, v};
		endfunction

		static function logic [31:0] sra(logic [31:0] v, int s);
			return $unsigned($signed(v) >>> s);
		endfunction

		// Signed division truncating toward zero, with wrap on overflow
		static function logic [31:0] quot(logic [31:0] a, logic [31:0] b);
			logic [31:0] ma;
			logic [31:0] mb;
			logic [31:0] q;
			ma = a[31] ? -a : a;
			mb = b[31] ? -b : b;
			q = ma / mb;
			return (a[31] != b[31]) ? -q : q;
		endfunction

		function void note_input(logic op, logic [18:0] raw);
			press_result_t r;
			logic [31:0] x1, x2, x3, den, b6, sq, b3, b4, b7, p, raw32;
			raw32 = {13'd0, raw};
			r.kind = op;
			r.value = '0;
			r.divide_error = 1'b0;
			if (op == bsc_pkg::OP_TEMP) begin
				x1 = sra(({16'd0, raw[15:0]} - {16'd0, temp_cal[47:32]})
					* {16'd0, temp_cal[63:48]}, 15);
				den = x1 + sext(temp_cal[15:0]);
				if (den == 0) begin
					r.divide_error = 1'b1;
				end else begin
					x2 = quot(sext(temp_cal[31:16]) << 11, den);
					b5 = x1 + x2;
					r.value = sra(b5 + 32'd8, 4);
				end
			end else begin
				b6 = b5 - 32'd4000;
				sq = sra(b6 * b6, 12);
				x1 = sra(sext(press_cal_b[15:0]) * sq, 11);
				x2 = sra(sext(press_cal_a[47:32]) * b6, 11);
				x3 = x1 + x2;
				b3 = sra(((sext(press_cal_a[63:48]) * 32'd4 + x3) << oss) + 32'd2, 2);
				x1 = sra(sext(press_cal_a[31:16]) * b6, 13);
				x2 = sra(sext(press_cal_b[31:16]) * sq, 16);
				x3 = sra(x1 + x2 + 32'd2, 2);
				b4 = ({16'd0, press_cal_a[15:0]} * (x3 + 32'd32768)) >> 15;
				b7 = (raw32 - b3) * (32'd50000 >> oss);
				if (b4 == 0) begin
					r.divide_error = 1'b1;
				end else begin
					if (!b7[31])
						p = (b7 << 1) / b4;
					else
						p = (b7 / b4) << 1;
					x1 = sra(p, 8) * sra(p, 8);
					x1 = sra(x1 * 32'd3038, 16);
					x2 = sra((32'd0 - 32'd7357) * p, 16);
					r.value = p + sra(x1 + x2 + 32'd3791, 4);
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(press_result_t got);
			press_result_t exp_r;
			if (pending.size() == 0) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("unexpected result word kind=%0d value=%0d err=%0d",
						got.kind, got.value, got.divide_error);
				end
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("mismatch: exp kind=%0d value=%0d err=%0d, got kind=%0d value=%0d err=%0d",
						exp_r.kind, exp_r.value, exp_r.divide_error,
						got.kind, got.value, got.divide_error);
				end
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              opcode;
	logic [18:0]       raw_sample;
	logic              out_valid;
	logic              out_ready;
	logic              kind;
	logic signed [31:0] value;
	logic              divide_error;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [63:0]       cfg_data;

	compensation_scoreboard board;
	bit quiet_tail;     // no idling in the last stretch
	int idle_cycles;

	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 100;

	barometric_sensor_compensation_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .raw_sample(raw_sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .value(value), .divide_error(divide_error),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Receiver: stall in random bursts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (quiet_tail)
				out_ready <= 1'b1;
			else if (!out_ready)
				out_ready <= ($urandom_range(0, 2) == 0);
			else
				out_ready <= ($urandom_range(0, 5) != 0);
		end
	end

	// Check every word that the next rising edge takes; handshake is stable here.
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result('{kind, value, divide_error});
	end

	// Watchdog: count cycles with no word moving on any channel.
	always @(negedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Send one sample word; the valid holds until accepted.
	task automatic send_sample(logic op, logic [18:0] raw);
		int gap;
		cfg_valid <= 1'b0;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		raw_sample <= raw;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		board.note_input(op, raw);
	endtask

	// Hold off until the block has returned every owed word, then let it settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		board.write_reg(idx, data);
	endtask

	// Typical factory coefficients with a little random spread
	task automatic load_typical(logic [1:0] os);
		logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6, mc, md, b1, b2;
		ac1 = 16'(408 + $urandom_range(0, 200));
		ac2 = 16'(-72 - $urandom_range(0, 20));
		ac3 = 16'(-14383 + $urandom_range(0, 400));
		ac4 = 16'(32741 + $urandom_range(0, 100));
		ac5 = 16'(32757 - $urandom_range(0, 8000));
		ac6 = 16'(23153 + $urandom_range(0, 500));
		mc = 16'(-8711 + $urandom_range(0, 200));
		md = 16'(2868 + $urandom_range(0, 200));
		b1 = 16'(6190 + $urandom_range(0, 100));
		b2 = 16'(4 + $urandom_range(0, 10));
		write_reg(bsc_pkg::REG_TEMP_CAL, {ac5, ac6, mc, md});
		write_reg(bsc_pkg::REG_PRESS_A, {ac1, ac2, ac3, ac4});
		write_reg(bsc_pkg::REG_PRESS_B, {32'd0, b1, b2});
		write_reg(bsc_pkg::REG_OSS, {62'd0, os});
	endtask

	initial begin
		logic [18:0] r;
		board = new();
		board.clear_state();
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = bsc_pkg::OP_TEMP;
		raw_sample = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = bsc_pkg::REG_TEMP_CAL;
		cfg_data = '0;
		quiet_tail = 1'b0;
		idle_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: all-zero calibration hits both zero-divisor paths; pressure
		// first uses the reset factor.
		send_sample(bsc_pkg::OP_PRESS, 19'd0);
		send_sample(bsc_pkg::OP_TEMP, 19'd0);
		send_sample(bsc_pkg::OP_PRESS, 19'h7FFFF);
		drain();

		// Temperature divisor zero: ut == ac6 leaves x1 = 0 and md is 0
		write_reg(bsc_pkg::REG_TEMP_CAL, {16'hFFFF, 16'h1234, 16'h8000, 16'h0000});
		send_sample(bsc_pkg::OP_TEMP, 19'h01234);
		send_sample(bsc_pkg::OP_TEMP, 19'h7FFFF);
		drain();

		// Negative divisor: x1 = 0 and md = -1, positive and negative numerators
		write_reg(bsc_pkg::REG_TEMP_CAL, {16'h0000, 16'h0000, 16'hFFF0, 16'hFFFF});
		send_sample(bsc_pkg::OP_TEMP, 19'h0);
		drain();
		write_reg(bsc_pkg::REG_TEMP_CAL, {16'h0000, 16'h0000, 16'h0010, 16'hFFFF});
		send_sample(bsc_pkg::OP_TEMP, 19'h0);
		drain();

		// Extreme calibration words, each oversampling setting
		for (int os = 0; os < 4; os++) begin
			write_reg(bsc_pkg::REG_TEMP_CAL, {4{16'hFFFF}});
			write_reg(bsc_pkg::REG_PRESS_A, os[0] ? {4{16'h8000}} : {4{16'h7FFF}});
			write_reg(bsc_pkg::REG_PRESS_B, os[1] ? 64'h8000_8000 : 64'h7FFF_7FFF);
			write_reg(bsc_pkg::REG_OSS, 64'(os));
			send_sample(bsc_pkg::OP_TEMP, 19'h0FFFF);
			send_sample(bsc_pkg::OP_PRESS, 19'h7FFFF);
			send_sample(bsc_pkg::OP_PRESS, 19'h40000);
			drain();
		end

		// Random phases: mostly realistic calibration, some fully random
		for (int ph = 0; ph < 16; ph++) begin
			if (ph % 4 == 3) begin
				write_reg(bsc_pkg::REG_TEMP_CAL, {$urandom, $urandom});
				write_reg(bsc_pkg::REG_PRESS_A, {$urandom, $urandom});
				write_reg(bsc_pkg::REG_PRESS_B, {32'd0, $urandom});
				write_reg(bsc_pkg::REG_OSS, 64'($urandom_range(0, 3)));
			end else begin
				load_typical(2'($urandom_range(0, 3)));
			end
			if (ph == 15)
				quiet_tail = 1'b1;
			for (int i = 0; i < 50; i++) begin
				if ($urandom_range(0, 2) == 0)
					send_sample(bsc_pkg::OP_TEMP, (i % 7 == 0) ? 19'($urandom)
						: 19'(27898 + $urandom_range(0, 8000) - 4000));
				else if ($urandom_range(0, 9) == 0)
					send_sample(bsc_pkg::OP_PRESS, 19'($urandom));
				else begin
					r = 19'(($urandom_range(20000, 30000) << 3) >> (8 - board.oss));
					send_sample(bsc_pkg::OP_PRESS, r);
				end
			end
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
